// ----- src/dmpid_pkg.sv -----
package dmpid_pkg;

	// Integral accumulator width (signed).
	localparam int ACC_WIDTH = 32;

	localparam int PULSE_W   = 16;
	localparam int ELAPSED_W = 16;
	localparam int TARGET_W  = 16;
	localparam int GAIN_W    = 32;
	localparam int DUTY_W    = 8;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam int SPEED_SCALE = 1000;
	localparam int FRAC_W      = 16;
	localparam int DUTY_MAX    = 255;

	// Dividend of the speed division: pulses * 1000.
	localparam int DVD_W = $clog2(((1 << PULSE_W) - 1) * SPEED_SCALE + 1);
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// Error, derivative and integral update widths.
	localparam int ERR_W  = DVD_W + 1;
	localparam int DER_W  = ERR_W + 1;
	localparam int ISUM_W = ((ACC_WIDTH > ERR_W) ? ACC_WIDTH : ERR_W) + 1;
	localparam int VAL_W  = (ACC_WIDTH > DER_W) ? ACC_WIDTH : DER_W;

	// The multiplier takes the operand magnitude in chunks of CHUNK_W bits.
	localparam int CHUNK_W     = 16;
	localparam int NCHUNK      = (VAL_W + CHUNK_W - 1) / CHUNK_W;
	localparam int MAG_PAD_W   = NCHUNK * CHUNK_W;
	localparam int CHUNK_IDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int PROD_W      = GAIN_W + CHUNK_W;
	localparam int SUM_W       = GAIN_W + MAG_PAD_W + 3;
	localparam int NUM_TERMS   = 3;

	localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(50);
	localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(1638400);
	localparam logic [GAIN_W-1:0]   GAIN_I_RST = GAIN_W'(983040);
	localparam logic [GAIN_W-1:0]   GAIN_D_RST = GAIN_W'(1966);

	localparam logic signed [ACC_WIDTH-1:0] IMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] IMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET,
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_DIV_WAIT,
		S_INTEG,
		S_ABS,
		S_MAC,
		S_DRAIN,
		S_CLAMP,
		S_OUT
	} pid_state_t;

	typedef struct packed {
		logic                   clear;
		logic                   step;
		logic                   neg;
		logic [CHUNK_IDX_W-1:0] shift;
	} mac_cmd_t;

endpackage

// ----- src/dmpid_in_if.sv -----
interface dmpid_in_if;
	import dmpid_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PULSE_W-1:0]   pulses_left;
	logic [PULSE_W-1:0]   pulses_right;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, output pulses_left, output pulses_right,
		output elapsed_ms, input ready);
	modport sink (input valid, input pulses_left, input pulses_right,
		input elapsed_ms, output ready);
endinterface

// ----- src/dmpid_out_if.sv -----
interface dmpid_out_if;
	import dmpid_pkg::*;

	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_left;
	logic [DUTY_W-1:0] duty_right;

	modport source (output valid, output duty_left, output duty_right, input ready);
	modport sink (input valid, input duty_left, input duty_right, output ready);
endinterface

// ----- src/dual_motor_pid_speed_control_unit.sv -----
// Dual-motor PID speed controller.
// Channel ticks carries one control tick: the encoder pulse counts of both
// motors and the milliseconds since the previous tick (zero is taken as one).
// Channel duties returns one transaction per tick with both PWM duties, 0..255.
// Both channels transfer when valid and ready are high at a rising clock edge.
// The configuration port writes target speed and the three Q16.16 gains at
// the edge where cfg_we is high; write it only while the block is idle.
// Per motor a restoring divider computes the speed, then a shared 32x16
// multiplier with accumulator forms the three gain products.
// The block takes one tick at a time; ready on ticks returns once the
// result is loaded into the output register.
// If the receiver stalls, the finished result waits in the sequencer and
// ticks stays not ready until the output register frees up.
// Reset restores the register defaults (target 50, gains 25.0, 15.0, 0.03)
// and clears both integrators and previous errors.
module dual_motor_pid_speed_control_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dmpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dmpid_pkg::CFG_W-1:0]     cfg_data,
	dmpid_in_if.sink                        ticks,
	dmpid_out_if.source                     duties
);
	import dmpid_pkg::*;

	pid_state_t state_q;
	pid_state_t state_d;

	logic [TARGET_W-1:0] target_q;
	logic [GAIN_W-1:0]   gain_p_q;
	logic [GAIN_W-1:0]   gain_i_q;
	logic [GAIN_W-1:0]   gain_d_q;

	logic                        motor_q;
	term_t                       term_q;
	logic [CHUNK_IDX_W-1:0]      chunk_q;
	logic signed [ACC_WIDTH-1:0] integral_q [2];
	logic signed [ERR_W-1:0]     prev_err_q [2];
	logic                        out_valid_q;

	logic [PULSE_W-1:0]          left_q;
	logic [PULSE_W-1:0]          right_q;
	logic [ELAPSED_W-1:0]        elapsed_q;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [ACC_WIDTH-1:0] integ_q;
	logic signed [DER_W-1:0]     deriv_q;
	logic [MAG_PAD_W-1:0]        mag_q [NUM_TERMS];
	logic                        neg_q [NUM_TERMS];
	logic [DUTY_W-1:0]           duty_left_q;
	logic [DUTY_W-1:0]           duty_right_q;
	logic [DUTY_W-1:0]           out_left_q;
	logic [DUTY_W-1:0]           out_right_q;

	logic                        div_start;
	logic                        div_done;
	logic [DVD_W-1:0]            dividend;
	logic [DVD_W-1:0]            speed;
	logic [ERR_W-1:0]            err_raw;
	logic signed [ISUM_W-1:0]    isum;
	logic signed [ACC_WIDTH-1:0] integ_new;
	logic signed [DER_W-1:0]     deriv_new;
	logic signed [VAL_W-1:0]     val [NUM_TERMS];
	mac_cmd_t                    mac_cmd;
	logic [GAIN_W-1:0]           gain_sel;
	logic [MAG_PAD_W-1:0]        mag_sel;
	logic                        neg_sel;
	logic [CHUNK_W-1:0]          operand;
	logic                        mac_last;
	logic [SUM_W-1:0]            mac_acc;
	logic [DUTY_W-1:0]           duty_new;
	logic                        out_load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET: target_q <= cfg_data[TARGET_W-1:0];
				CFG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Speed division.
	assign dividend = (motor_q ? DVD_W'(right_q) : DVD_W'(left_q)) * DVD_W'(SPEED_SCALE);

	dmpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (speed)
	);

	// Error, saturated integral and derivative.
	assign err_raw = ERR_W'(target_q) - ERR_W'(speed);
	assign isum = ISUM_W'(integral_q[motor_q]) + ISUM_W'(err_q);
	assign deriv_new = DER_W'(err_q) - DER_W'(prev_err_q[motor_q]);

	always_comb begin
		priority if (isum > ISUM_W'(IMAX)) begin
			integ_new = IMAX;
		end else if (isum < ISUM_W'(IMIN)) begin
			integ_new = IMIN;
		end else begin
			integ_new = isum[ACC_WIDTH-1:0];
		end
	end

	assign val[0] = VAL_W'(err_q);
	assign val[1] = VAL_W'(integ_q);
	assign val[2] = VAL_W'(deriv_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (term_q)
			TERM_P: begin
				gain_sel = gain_p_q;
				mag_sel  = mag_q[0];
				neg_sel  = neg_q[0];
			end
			TERM_I: begin
				gain_sel = gain_i_q;
				mag_sel  = mag_q[1];
				neg_sel  = neg_q[1];
			end
			TERM_D: begin
				gain_sel = gain_d_q;
				mag_sel  = mag_q[2];
				neg_sel  = neg_q[2];
			end
			default: begin
				gain_sel = '0;
				mag_sel  = '0;
				neg_sel  = 1'b0;
			end
		endcase
	end

	assign operand  = mag_sel[chunk_q * CHUNK_W +: CHUNK_W];
	assign mac_last = (term_q == TERM_D) && (chunk_q == CHUNK_IDX_W'(NCHUNK - 1));

	dmpid_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mac_cmd),
		.gain    (gain_sel),
		.operand (operand),
		.acc     (mac_acc)
	);

	// A negative sum gives zero; anything at or above 256.0 clamps to 255.
	always_comb begin
		priority if (mac_acc[SUM_W-1]) begin
			duty_new = '0;
		end else if (|mac_acc[SUM_W-2:FRAC_W+DUTY_W]) begin
			duty_new = DUTY_W'(DUTY_MAX);
		end else begin
			duty_new = mac_acc[FRAC_W+DUTY_W-1:FRAC_W];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ticks.ready = 1'b0;
		div_start   = 1'b0;
		mac_cmd     = '0;
		out_load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ticks.ready = 1'b1;
				if (ticks.valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				div_start = 1'b1;
				state_d   = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = S_INTEG;
				end
			end
			S_INTEG: begin
				state_d = S_ABS;
			end
			S_ABS: begin
				mac_cmd.clear = 1'b1;
				state_d       = S_MAC;
			end
			S_MAC: begin
				mac_cmd.step  = 1'b1;
				mac_cmd.neg   = neg_sel;
				mac_cmd.shift = chunk_q;
				if (mac_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				state_d = motor_q ? S_OUT : S_DIV;
			end
			S_OUT: begin
				if (!out_valid_q || duties.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control counters, controller state and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_q       <= 1'b0;
			term_q        <= TERM_P;
			chunk_q       <= '0;
			integral_q[0] <= '0;
			integral_q[1] <= '0;
			prev_err_q[0] <= '0;
			prev_err_q[1] <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (duties.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					motor_q <= 1'b0;
				end
				S_INTEG: begin
					integral_q[motor_q] <= integ_new;
					prev_err_q[motor_q] <= err_q;
				end
				S_ABS: begin
					term_q  <= TERM_P;
					chunk_q <= '0;
				end
				S_MAC: begin
					if (chunk_q == CHUNK_IDX_W'(NCHUNK - 1)) begin
						chunk_q <= '0;
						unique case (term_q)
							TERM_P:  term_q <= TERM_I;
							TERM_I:  term_q <= TERM_D;
							default: term_q <= TERM_P;
						endcase
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_CLAMP: begin
					motor_q <= ~motor_q;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			left_q    <= ticks.pulses_left;
			right_q   <= ticks.pulses_right;
			elapsed_q <= (ticks.elapsed_ms == '0) ? ELAPSED_W'(1) : ticks.elapsed_ms;
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			err_q <= err_raw;
		end
		if (state_q == S_INTEG) begin
			integ_q <= integ_new;
			deriv_q <= deriv_new;
		end
		if (state_q == S_ABS) begin
			for (int i = 0; i < NUM_TERMS; i++) begin
				neg_q[i] <= val[i][VAL_W-1];
				mag_q[i] <= MAG_PAD_W'(val[i][VAL_W-1] ? (~val[i] + 1'b1) : val[i]);
			end
		end
		if (state_q == S_CLAMP) begin
			if (motor_q) begin
				duty_right_q <= duty_new;
			end else begin
				duty_left_q <= duty_new;
			end
		end
		if (out_load) begin
			out_left_q  <= duty_left_q;
			out_right_q <= duty_right_q;
		end
	end

	assign duties.valid      = out_valid_q;
	assign duties.duty_left  = out_left_q;
	assign duties.duty_right = out_right_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside of the wait state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(ticks.valid && ticks.ready) |=> !ticks.ready)
		else $error("ticks stayed ready after accepting a transaction");

	a_result_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(duties.valid) |-> $past(state_q) == S_OUT)
		else $error("result became valid without passing the output state");
endmodule

// ----- src/dmpid_div.sv -----
module dmpid_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dmpid_pkg::DVD_W-1:0]     dividend,
	input  logic [dmpid_pkg::ELAPSED_W-1:0] divisor,
	output logic                            done,
	output logic [dmpid_pkg::DVD_W-1:0]     quotient
);
	import dmpid_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ELAPSED_W-1:0] rem_q;
	logic [ELAPSED_W-1:0] dvs_q;
	logic [DVD_W-1:0]     quo_q;
	logic [ELAPSED_W:0]   shifted;
	logic [ELAPSED_W:0]   trial;
	logic                 fits;
	logic                 last;

	// One restoring step per cycle: the dividend shifts out of the top of quo_q
	// while quotient bits shift in at the bottom.
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = ~trial[ELAPSED_W];
	assign last    = (cnt_q == DIV_CNT_W'(DVD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[ELAPSED_W-1:0] : shifted[ELAPSED_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- src/dmpid_mac.sv -----
module dmpid_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dmpid_pkg::mac_cmd_t           cmd,
	input  logic [dmpid_pkg::GAIN_W-1:0]  gain,
	input  logic [dmpid_pkg::CHUNK_W-1:0] operand,
	output logic [dmpid_pkg::SUM_W-1:0]   acc
);
	import dmpid_pkg::*;

	logic                   valid_s1;
	logic [PROD_W-1:0]      prod_s1;
	logic                   neg_s1;
	logic [CHUNK_IDX_W-1:0] shift_s1;
	logic [SUM_W-1:0]       acc_q;
	logic [SUM_W-1:0]       term;
	logic [SUM_W-1:0]       addend;

	// A negative term is added as its one's complement with a carry in.
	assign term   = SUM_W'(prod_s1) << (CHUNK_W * shift_s1);
	assign addend = term ^ {SUM_W{neg_s1}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			prod_s1  <= PROD_W'(gain) * PROD_W'(operand);
			neg_s1   <= cmd.neg;
			shift_s1 <= cmd.shift;
		end
		if (cmd.clear) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_q + addend + SUM_W'(neg_s1);
		end
	end

	assign acc = acc_q;
endmodule

// ----- verif/dual_motor_pid_speed_control_unit_tb.sv -----
`timescale 1ns / 1ps

module dual_motor_pid_speed_control_unit_tb;
	import dmpid_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 600;
	localparam int END_WAIT    = 100;

	typedef struct packed {
		logic [DUTY_W-1:0] left;
		logic [DUTY_W-1:0] right;
	} duty_pair_t;

	// Tracks both control loops and the duties they must produce, one pair per tick.
	class duty_scoreboard;
		logic [TARGET_W-1:0] target_speed;
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   ki;
		logic [GAIN_W-1:0]   kd;
		longint              integ [2];
		longint              last_err [2];
		duty_pair_t          expected_duties [$];
		int                  errors;

		function new();
			target_speed = TARGET_RST;
			kp = GAIN_P_RST;
			ki = GAIN_I_RST;
			kd = GAIN_D_RST;
			integ = '{0, 0};
			last_err = '{0, 0};
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_TARGET: target_speed = val[TARGET_W-1:0];
				CFG_GAIN_P: kp = val[GAIN_W-1:0];
				CFG_GAIN_I: ki = val[GAIN_W-1:0];
				CFG_GAIN_D: kd = val[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Exact gain * value product; the gain is unsigned, the value signed.
		function logic signed [127:0] gain_term(logic [GAIN_W-1:0] g, longint v);
			logic signed [127:0] g_w;
			logic signed [127:0] v_w;
			g_w = {96'd0, g};
			v_w = v;
			return g_w * v_w;
		endfunction

		function logic [DUTY_W-1:0] motor_duty(int m, logic [PULSE_W-1:0] pulses,
				logic [ELAPSED_W-1:0] elapsed);
			longint cnt, ms, tgt, spd, err, sum, der, imax, imin;
			logic signed [127:0] ctl;
			logic signed [127:0] q;
			cnt = pulses;
			ms = elapsed;
			tgt = target_speed;
			imax = IMAX;
			imin = IMIN;
			spd = (cnt * 1000) / ms;
			err = tgt - spd;
			sum = integ[m] + err;
			if (sum > imax)
				sum = imax;
			if (sum < imin)
				sum = imin;
			integ[m] = sum;
			der = err - last_err[m];
			last_err[m] = err;
			ctl = gain_term(kp, err) + gain_term(ki, sum) + gain_term(kd, der);
			if (ctl < 0)
				return '0;
			q = ctl >>> FRAC_W;
			if (q > DUTY_MAX)
				return DUTY_W'(DUTY_MAX);
			return q[DUTY_W-1:0];
		endfunction

		function void note_tick(logic [PULSE_W-1:0] left, logic [PULSE_W-1:0] right,
				logic [ELAPSED_W-1:0] elapsed);
			duty_pair_t want;
			logic [ELAPSED_W-1:0] ms;
			// A zero interval counts as one millisecond.
			ms = (elapsed == 0) ? ELAPSED_W'(1) : elapsed;
			want.left = motor_duty(0, left, ms);
			want.right = motor_duty(1, right, ms);
			expected_duties.push_back(want);
		endfunction

		function void check_duties(logic [DUTY_W-1:0] left, logic [DUTY_W-1:0] right);
			duty_pair_t want;
			if (expected_duties.size() == 0) begin
				$display("%0t: unexpected duty transaction, left %0d right %0d",
					$time, left, right);
				errors++;
				return;
			end
			want = expected_duties.pop_front();
			if (want.left !== left) begin
				$display("%0t: duty_left expected %0d, actual %0d", $time, want.left, left);
				errors++;
			end
			if (want.right !== right) begin
				$display("%0t: duty_right expected %0d, actual %0d", $time, want.right, right);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int src_idle_pct = 31;
	int sink_idle_pct = 87;
	bit hold_req = 1'b0;
	int cycles = 0;

	duty_scoreboard sb = new();

	dmpid_in_if  ticks_if();
	dmpid_out_if duties_if();

	dual_motor_pid_speed_control_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ticks     (ticks_if),
		.duties    (duties_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Duty receiver: checks each transaction and throttles ready.
	initial begin : duty_sink
		int hold_left;
		hold_left = 0;
		duties_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (duties_if.valid === 1'b1 && duties_if.ready === 1'b1)
				sb.check_duties(duties_if.duty_left, duties_if.duty_right);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				duties_if.ready <= 1'b0;
			end else begin
				duties_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	task automatic send_tick(logic [PULSE_W-1:0] left, logic [PULSE_W-1:0] right,
			logic [ELAPSED_W-1:0] elapsed);
		if ($urandom_range(99, 0) < src_idle_pct) begin
			ticks_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < src_idle_pct);
		end
		ticks_if.valid <= 1'b1;
		ticks_if.pulses_left <= left;
		ticks_if.pulses_right <= right;
		ticks_if.elapsed_ms <= elapsed;
		do @(posedge clk); while (ticks_if.ready !== 1'b1);
		sb.note_tick(left, right, elapsed);
	endtask

	// Emulates a motor that runs near the setpoint, offset so the integrator is
	// pulled back toward zero; this keeps many duties off the clamps.
	function automatic logic [PULSE_W-1:0] pulses_for_speed(longint integ,
			logic [ELAPSED_W-1:0] elapsed);
		longint spd, cnt, ms;
		ms = elapsed;
		spd = sb.target_speed;
		spd = spd + integ / 2 + (int'($urandom_range(80, 0)) - 40);
		if (spd < 0)
			spd = 0;
		if (spd > 65535000)
			spd = 65535000;
		cnt = (spd * ms + 500) / 1000;
		if (cnt > 65535)
			cnt = 65535;
		return cnt[PULSE_W-1:0];
	endfunction

	function automatic logic [15:0] corner_value();
		case ($urandom_range(3, 0))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_ticks(int n);
		logic [PULSE_W-1:0]   left, right;
		logic [ELAPSED_W-1:0] elapsed;
		int pick;
		repeat (n) begin
			pick = $urandom_range(99, 0);
			if (pick < 65) begin
				if (pick < 8)
					elapsed = 16'($urandom_range(65535, 1));
				else
					elapsed = 16'($urandom_range(1000, 1));
				left = pulses_for_speed(sb.integ[0], elapsed);
				right = pulses_for_speed(sb.integ[1], elapsed);
			end else if (pick < 85) begin
				left = 16'($urandom);
				right = 16'($urandom);
				elapsed = 16'($urandom);
			end else begin
				left = corner_value();
				right = corner_value();
				elapsed = corner_value();
			end
			send_tick(left, right, elapsed);
		end
	endtask

	task automatic directed_ticks();
		send_tick(16'd0, 16'd0, 16'd0);
		send_tick(16'd0, 16'd0, 16'd1);
		send_tick(16'd50, 16'd50, 16'd1000);
		send_tick(16'd49, 16'd51, 16'd1000);
		send_tick(16'd51, 16'd49, 16'd1000);
		send_tick(16'd5, 16'd5, 16'd100);
		send_tick(16'd1, 16'd2, 16'd3);
		send_tick(16'hFFFF, 16'hFFFF, 16'd1);
		send_tick(16'hFFFF, 16'd0, 16'hFFFF);
		send_tick(16'd0, 16'hFFFF, 16'hFFFF);
		send_tick(16'h8000, 16'd1, 16'd2);
		send_tick(16'hAAAA, 16'h5555, 16'h5555);
		send_tick(16'h5555, 16'hAAAA, 16'hAAAA);
		send_tick(16'd0, 16'd0, 16'h8000);
		send_tick(16'd50, 16'd0, 16'd0);
		send_tick(16'd0, 16'd50, 16'd1000);
	endtask

	// Valid is lowered in the step of the last accepted tick, then every
	// outstanding duty pair is collected so the block is idle afterwards.
	task automatic drain();
		ticks_if.valid <= 1'b0;
		while (sb.expected_duties.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(logic [TARGET_W-1:0] tgt, logic [GAIN_W-1:0] p,
			logic [GAIN_W-1:0] i, logic [GAIN_W-1:0] d);
		cfg_reg_t         regs [4];
		logic [CFG_W-1:0] vals [4];
		regs = '{CFG_TARGET, CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D};
		vals = '{{16'd0, tgt}, p, i, d};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			@(posedge clk);
			sb.write_reg(regs[k], vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TARGET;
		cfg_data <= '0;
		ticks_if.valid <= 1'b0;
		ticks_if.pulses_left <= '0;
		ticks_if.pulses_right <= '0;
		ticks_if.elapsed_ms <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver heavily.
		src_idle_pct = 31;
		sink_idle_pct = 87;
		directed_ticks();
		random_ticks(200);
		drain();

		load_settings(16'd1000, 32'h0001_0000, 32'h0000_2000, 32'h0000_8000);
		random_ticks(20);
		// Long receiver stall while ticks keep coming, so the input backs up.
		hold_req = 1'b1;
		random_ticks(180);
		drain();

		load_settings(16'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		random_ticks(200);
		drain();

		// Roles swapped: sender idles heavily, receiver lightly.
		src_idle_pct = 87;
		sink_idle_pct = 31;
		load_settings(16'hFFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		random_ticks(200);
		drain();

		load_settings(16'($urandom_range(2000, 0)), 32'($urandom_range(32'h40000, 0)),
			32'($urandom_range(32'h4000, 0)), 32'($urandom_range(32'h40000, 0)));
		random_ticks(200);
		drain();

		load_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_ticks(200);
		drain();

		// Back-to-back traffic on both sides.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		load_settings(16'($urandom), $urandom, $urandom, $urandom);
		random_ticks(200);
		drain();

		// Drive both integrators into negative saturation, then let them climb;
		// the gains make the duty follow the saturated value closely.
		load_settings(16'hFFFF, 32'h0000_8100, 32'h0000_0001, 32'h0000_0000);
		repeat (40)
			send_tick(16'hFFFF, 16'hFFFF, 16'd1);
		random_ticks(160);
		drain();

		repeat (END_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.expected_duties.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
